// ----- src/qbt_packet_deframer_assert.svh -----
// assertion macros for the packet deframer
// expects clk and rst in the scope of the module that uses them
`ifndef QBT_PACKET_DEFRAMER_ASSERT_SVH
`define QBT_PACKET_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS
// condition that holds at every clock edge outside reset
`define QBT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// antecedent in one cycle implies consequent in the next
`define QBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define QBT_ASSERT_ALWAYS(lbl, cond, msg)
`define QBT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- src/qbt_dfr_pkg.sv -----
// shared types and constants of the packet deframer
// sync prefix pattern, result record and cell control group; no dependencies
package qbt_dfr_pkg;

  localparam int PREFIX_LEN = 42;
  localparam int IDX_W      = 11;

  // sync prefix, oldest byte at index 0
  localparam logic [7:0] PFX_VALUE [PREFIX_LEN] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h2F, 8'h50, 8'h46, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h2F, 8'h50, 8'h4E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h2F, 8'h50, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h2F,
    8'h43, 8'h53
  };

  // bit i set where prefix byte i must match
  localparam logic [PREFIX_LEN-1:0] PFX_CARE =
    (PREFIX_LEN)'((64'h1 << 9) - 64'h1)
    | ((PREFIX_LEN)'(64'h7) << 21)
    | ((PREFIX_LEN)'(64'h7) << 30)
    | ((PREFIX_LEN)'(64'h7) << 39);

  typedef struct packed {
    logic             aborted;
    logic             last;
    logic [IDX_W-1:0] index;
    logic [7:0]       data;
  } result_t;

  typedef struct packed {
    logic shift;  // move bytes one cell on, update candidates
    logic flush;  // drop older candidates before this byte
    logic kill;   // clear every candidate
  } cell_ctrl_t;

endpackage

// ----- src/qbt_dfr_cell.sv -----
// one cell of the hunt chain: one window byte and one candidate flag
// depends on qbt_dfr_pkg
module qbt_dfr_cell
  import qbt_dfr_pkg::*;
#(
  parameter logic [7:0] MATCH_VALUE = 8'h00,
  parameter bit         MATCH_CARE  = 1'b0
) (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic [7:0] new_byte,
  input  logic [7:0] byte_in,
  input  logic       alive_in,
  output logic [7:0] byte_q,
  output logic       alive_q,
  output logic       hit
);

  // candidate that reached this age survives the new byte
  assign hit = alive_in && (!MATCH_CARE || new_byte == MATCH_VALUE);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      byte_q <= byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alive_q <= 1'b0;
    end else if (ctrl.kill) begin
      alive_q <= 1'b0;
    end else if (ctrl.shift) begin
      alive_q <= hit;
    end
  end

endmodule

// ----- src/qbt_dfr_chain.sv -----
// hunt chain: a row of cells, newest byte in cell 0, oldest in the last cell
// depends on qbt_dfr_pkg and qbt_dfr_cell
module qbt_dfr_chain
  import qbt_dfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic [7:0] new_byte,
  output logic [7:0] oldest_byte,
  output logic       done
);

  logic [7:0]            byte_q [PREFIX_LEN];
  logic [PREFIX_LEN-1:0] alive_q;
  logic [PREFIX_LEN-1:0] hit;

  for (genvar k = 0; k < PREFIX_LEN; k++) begin : g_cell
    logic [7:0] byte_in;
    logic       alive_in;

    if (k == 0) begin : g_head
      // a fresh candidate starts on every byte
      assign byte_in  = new_byte;
      assign alive_in = 1'b1;
    end else begin : g_body
      assign byte_in  = byte_q[k-1];
      assign alive_in = alive_q[k-1] && !ctrl.flush;
    end

    qbt_dfr_cell #(
      .MATCH_VALUE (PFX_VALUE[k]),
      .MATCH_CARE  (PFX_CARE[k])
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .new_byte (new_byte),
      .byte_in  (byte_in),
      .alive_in (alive_in),
      .byte_q   (byte_q[k]),
      .alive_q  (alive_q[k]),
      .hit      (hit[k])
    );
  end

  assign oldest_byte = byte_q[PREFIX_LEN-1];
  assign done        = hit[PREFIX_LEN-1];

endmodule

// ----- src/qbt_dfr_skid.sv -----
// two-entry output stage: output register plus skid register
// depends on qbt_dfr_pkg
module qbt_dfr_skid
  import qbt_dfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push_valid,
  input  result_t push_data,
  output logic    push_ready,
  output logic    out_valid,
  output result_t out_data,
  input  logic    out_ready
);

  logic    skid_valid;
  result_t skid_data;

  assign push_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push_valid;
        out_data  <= push_data;
      end
    end else if (push_valid) begin
      skid_valid <= 1'b1;
      skid_data  <= push_data;
    end
  end

endmodule

// ----- src/qbt_packet_deframer.sv -----
// top level of the packet deframer: sequencer, counter gap check, stream ports
// depends on qbt_dfr_pkg, qbt_dfr_chain, qbt_dfr_skid and the assertion header
//
//   port group  dir  tdata                              tuser           tlast
//   s_axis      in   data_byte, fragment_counter        fragment_start  -
//   m_axis      out  packet_byte, byte_index            aborted         last_of_packet
//
// one input byte per cycle while hunting or streaming a locked packet and the output stage has room
// a full prefix match holds s_axis_tready low while the window drains out
//   of the hunt chain, oldest byte first
// results pass a two-entry output stage, so s_axis_tready depends only on
//   registered state; a stalled m_axis side stops input once both entries fill
// synchronous reset clears the sequencer, candidates and the counter history
`include "qbt_packet_deframer_assert.svh"

module qbt_packet_deframer
  import qbt_dfr_pkg::*;
#(
  parameter int PACKET_BYTES = 1116,
  parameter int COUNTER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] data_byte, [23:8] fragment_counter
  input  logic        s_axis_tuser,   // fragment_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] packet_byte, [18:8] byte_index, rest zero
  output logic        m_axis_tlast,   // last_of_packet
  output logic        m_axis_tuser    // aborted
);

  localparam int CTR_W = (COUNTER_BITS < 16) ? COUNTER_BITS : 16;
  // one extra bit above 16 keeps wrap of a wider counter distinct
  localparam int GAP_W = (COUNTER_BITS <= 16) ? COUNTER_BITS : 17;
  localparam int POS_W = $clog2(PACKET_BYTES);
  localparam int REL_W = $clog2(PREFIX_LEN);

  typedef enum logic [1:0] {
    MODE_HUNT,
    MODE_RELEASE,
    MODE_STREAM
  } mode_t;

  mode_t            mode;
  logic [REL_W-1:0] rel_idx;
  logic [POS_W-1:0] pos;
  logic [CTR_W-1:0] prev_ctr;

  logic [7:0]       in_byte;
  logic [CTR_W-1:0] in_ctr;
  logic [GAP_W-1:0] gap;
  logic             gap_hit;
  logic             in_accept;
  logic             abort_now;
  logic             stream_now;
  logic             hunt_now;
  logic             rel_push;
  logic             done;
  logic [7:0]       oldest_byte;
  cell_ctrl_t       ctrl;
  logic             push_valid;
  logic             push_ready;
  result_t          push_data;
  result_t          out_data;

  assign in_byte = s_axis_tdata[7:0];
  assign in_ctr  = s_axis_tdata[8 +: CTR_W];

  // counter gap modulo the counter range, checked on fragment start only
  assign gap     = GAP_W'(in_ctr) - GAP_W'(prev_ctr);
  assign gap_hit = s_axis_tuser && (gap > GAP_W'(1));

  assign s_axis_tready = (mode != MODE_RELEASE) && push_ready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // a gap while locked gives an abort marker, then the byte is hunted
  assign abort_now  = in_accept && (mode == MODE_STREAM) && gap_hit;
  assign stream_now = in_accept && (mode == MODE_STREAM) && !gap_hit;
  assign hunt_now   = in_accept && (mode != MODE_STREAM || gap_hit);
  assign rel_push   = (mode == MODE_RELEASE) && push_ready;

  always_comb begin
    ctrl.shift = hunt_now || rel_push;
    ctrl.flush = hunt_now && gap_hit;
    ctrl.kill  = rel_push || (hunt_now && done);
  end

  qbt_dfr_chain u_chain (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .new_byte    (in_byte),
    .oldest_byte (oldest_byte),
    .done        (done)
  );

  // at most one result per cycle into the output stage
  always_comb begin
    push_valid = 1'b0;
    push_data  = '0;
    priority if (rel_push) begin
      push_valid     = 1'b1;
      push_data.data = oldest_byte;
      push_data.index = IDX_W'(rel_idx);
      push_data.last = (int'(rel_idx) == PACKET_BYTES - 1);
    end else if (abort_now) begin
      push_valid        = 1'b1;
      push_data.index   = IDX_W'(pos);
      push_data.last    = 1'b1;
      push_data.aborted = 1'b1;
    end else if (stream_now) begin
      push_valid      = 1'b1;
      push_data.data  = in_byte;
      push_data.index = IDX_W'(pos);
      push_data.last  = (pos == POS_W'(PACKET_BYTES - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_HUNT;
      rel_idx  <= '0;
      pos      <= '0;
      prev_ctr <= '0;
    end else begin
      if (in_accept && s_axis_tuser) begin
        prev_ctr <= in_ctr;
      end
      unique case (mode)
        MODE_HUNT: begin
          if (hunt_now && done) begin
            mode    <= MODE_RELEASE;
            rel_idx <= '0;
          end
        end
        MODE_RELEASE: begin
          if (rel_push) begin
            if (rel_idx == REL_W'(PREFIX_LEN - 1)) begin
              rel_idx <= '0;
              if (PACKET_BYTES > PREFIX_LEN) begin
                mode <= MODE_STREAM;
                pos  <= POS_W'(PREFIX_LEN);
              end else begin
                mode <= MODE_HUNT;
              end
            end else begin
              rel_idx <= rel_idx + REL_W'(1);
            end
          end
        end
        MODE_STREAM: begin
          if (abort_now) begin
            // the hunted byte after an abort cannot finish a prefix
            mode <= MODE_HUNT;
            pos  <= '0;
          end else if (stream_now) begin
            if (pos == POS_W'(PACKET_BYTES - 1)) begin
              mode <= MODE_HUNT;
              pos  <= '0;
            end else begin
              pos <= pos + POS_W'(1);
            end
          end
        end
        default: begin
          mode <= MODE_HUNT;
        end
      endcase
    end
  end

  qbt_dfr_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .out_valid  (m_axis_tvalid),
    .out_data   (out_data),
    .out_ready  (m_axis_tready)
  );

  assign m_axis_tdata = {(24 - IDX_W - 8)'(0), out_data.index, out_data.data};
  assign m_axis_tlast = out_data.last;
  assign m_axis_tuser = out_data.aborted;

  // no input transaction while the window drains
  `QBT_ASSERT_ALWAYS(a_no_accept_in_release, !(mode == MODE_RELEASE && in_accept),
    "input accepted during release")
  // a completed prefix always starts the release
  `QBT_ASSERT_NEXT(a_done_to_release, hunt_now && done, mode == MODE_RELEASE,
    "prefix match did not start release")
  // an abort always returns to hunting
  `QBT_ASSERT_NEXT(a_abort_to_hunt, abort_now, mode == MODE_HUNT,
    "abort did not return to hunting")
  // the output stage is never pushed when full
  `QBT_ASSERT_ALWAYS(a_push_when_ready, !(push_valid && !push_ready),
    "result pushed into a full output stage")

endmodule
